FILE: design/assert_macros.svh
// Assertion macros used by the decoder top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checked on every rising edge and switched off while reset is low.
`define ASSERT_RST(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Checked on every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_RST(lbl, clk, rstn, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

FILE: design/utf8sd_pkg.sv
// Types, constants and helpers shared by the UTF-8 stream decoder.
package utf8sd_pkg;

  localparam logic [20:0] REPL_CP  = 21'h00FFFD;
  localparam logic [20:0] MAX_CP   = 21'h10FFFF;
  localparam logic [20:0] MIN_CP_2 = 21'h000080;
  localparam logic [20:0] MIN_CP_3 = 21'h000800;
  localparam logic [20:0] MIN_CP_4 = 21'h010000;

  // Sequence lengths as announced by a lead byte.
  localparam logic [2:0] LEN_BAD  = 3'd0;
  localparam logic [2:0] LEN_ONE  = 3'd1;
  localparam logic [2:0] LEN_TWO  = 3'd2;
  localparam logic [2:0] LEN_THR  = 3'd3;
  localparam logic [2:0] LEN_FOUR = 3'd4;

  // Decoder state carried from one byte to the next.
  typedef struct packed {
    logic [20:0] acc;
    logic [2:0]  exp_len;
    logic [2:0]  seen;
  } dec_state_t;

  // All results of one byte: replacements, an optional main item, replacements.
  typedef struct packed {
    logic [1:0]  n_pre;
    logic        has_main;
    logic [20:0] cp;
    logic        ok;
    logic [2:0]  cnt;
    logic [1:0]  n_post;
    logic        eot;
  } burst_t;

  // Number of result items that a burst holds.
  function automatic logic [2:0] burst_len(burst_t b);
    return {1'b0, b.n_pre} + {2'b00, b.has_main} + {1'b0, b.n_post};
  endfunction

endpackage

FILE: design/utf8_stream_decoder.sv
// Top level of the streaming UTF-8 decoder with its result queue.
//
//  Channel   Dir  tdata bits                          tuser      tlast
//  s_axis    in   [7:0] in_byte                       -          end_of_text
//  m_axis    out  [20:0] code_point, [23:21]          valid_res  text_done
//                 byte_count, [24] last_of_run
//
// One byte is accepted per cycle while the queue has room; its state update
// and all of its results are formed in that cycle and stored, if it has any,
// as one entry of a two-entry result queue. Results leave one per cycle while
// m_axis_tready_i is high, up to four per byte; input stalls only while both
// queue entries are held. Reset clears the decoder state and the queue at once.
module utf8_stream_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] in_byte
  input  logic        s_axis_tlast_i,   // end_of_text
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [20:0] code_point, [23:21] byte_count,
                                        // [24] last_of_run, rest zero
  output logic        m_axis_tuser_o,   // [0] valid_res
  output logic        m_axis_tlast_o    // text_done
);
  import utf8sd_pkg::*;

`include "assert_macros.svh"

  dec_state_t st_q, st_d;
  burst_t     burst;
  burst_t     q_mem [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q, cnt_d;
  logic [1:0] pos_q;
  logic       s_acc, m_acc, push, pop;
  burst_t     head;
  logic [2:0] total;
  logic       is_main, is_last;
  logic [20:0] out_cp;
  logic        out_ok;
  logic [2:0]  out_cnt;

  utf8sd_decode u_decode (
    .st_i    (st_q),
    .byte_i  (s_axis_tdata_i),
    .eot_i   (s_axis_tlast_i),
    .st_o    (st_d),
    .burst_o (burst)
  );

  // Handshakes and queue control.
  assign s_axis_tready_o = (cnt_q != 2'd2);
  assign m_axis_tvalid_o = (cnt_q != 2'd0);
  assign s_acc = s_axis_tvalid_i && s_axis_tready_o;
  assign m_acc = m_axis_tvalid_o && m_axis_tready_i;
  assign push  = s_acc && (burst_len(burst) != 3'd0);
  assign pop   = m_acc && is_last;

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  // Decoder state and queue pointers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= '0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
      pos_q    <= 2'd0;
    end else begin
      if (s_acc) begin
        st_q <= st_d;
      end
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
        pos_q    <= 2'd0;
      end else if (m_acc) begin
        pos_q <= pos_q + 2'd1;
      end
      cnt_q <= cnt_d;
    end
  end

  // Queue storage holds payload only.
  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= burst;
    end
  end

  // Pick the current item out of the head entry.
  assign head    = q_mem[rd_ptr_q];
  assign total   = burst_len(head);
  assign is_main = head.has_main && (pos_q == head.n_pre);
  assign is_last = (({1'b0, pos_q} + 3'd1) == total);
  assign out_cp  = is_main ? head.cp  : REPL_CP;
  assign out_ok  = is_main ? head.ok  : 1'b0;
  assign out_cnt = is_main ? head.cnt : 3'd1;

  assign m_axis_tdata_o = {7'b0, is_last, out_cnt, out_cp};
  assign m_axis_tuser_o = out_ok;
  assign m_axis_tlast_o = is_last && head.eot;

  // Checks on queue and decoder consistency.
  `ASSERT_ALWAYS(a_cnt_range, clk_i, (!rst_ni || (cnt_q != 2'd3)),
                 "result queue count out of range")
  `ASSERT_RST(a_head_len, clk_i, rst_ni,
              m_axis_tvalid_o |-> ((total != 3'd0) && (total <= 3'd4) &&
                                   ({1'b0, pos_q} < total)),
              "head entry position out of range")
  `ASSERT_RST(a_eot_clear, clk_i, rst_ni,
              (s_acc && s_axis_tlast_i) |=> (st_q.exp_len == 3'd0),
              "state left pending after end of text")
  `ASSERT_RST(a_done_last, clk_i, rst_ni,
              (m_axis_tvalid_o && m_axis_tlast_o) |-> m_axis_tdata_o[24],
              "text_done without last_of_run")

endmodule

FILE: design/utf8sd_decode.sv
// Combinational step of the decoder: next state and the results of one byte.
module utf8sd_decode (
  input  utf8sd_pkg::dec_state_t st_i,
  input  logic [7:0]             byte_i,
  input  logic                   eot_i,
  output utf8sd_pkg::dec_state_t st_o,
  output utf8sd_pkg::burst_t     burst_o
);
  import utf8sd_pkg::*;

  logic        is_cont;
  logic [2:0]  lead_len;
  logic [20:0] lead_bits;
  logic [20:0] acc_new;
  logic [2:0]  seen_new;
  logic        bad;
  logic        do_lead;

  // Classify the byte as a continuation or a lead of some length.
  always_comb begin
    is_cont   = (byte_i[7:6] == 2'b10);
    lead_len  = LEN_BAD;
    lead_bits = '0;
    priority if (byte_i[7] == 1'b0) begin
      lead_len = LEN_ONE;
    end else if (byte_i[7:5] == 3'b110) begin
      lead_len  = LEN_TWO;
      lead_bits = {16'b0, byte_i[4:0]};
    end else if (byte_i[7:4] == 4'b1110) begin
      lead_len  = LEN_THR;
      lead_bits = {17'b0, byte_i[3:0]};
    end else if (byte_i[7:3] == 5'b11110) begin
      lead_len  = LEN_FOUR;
      lead_bits = {18'b0, byte_i[2:0]};
    end else begin
      lead_len = LEN_BAD;
    end
  end

  // Advance the pending sequence, then decode the byte as a lead if not consumed.
  always_comb begin
    st_o             = st_i;
    burst_o          = '0;
    burst_o.cp       = REPL_CP;
    burst_o.cnt      = 3'd1;
    acc_new          = {st_i.acc[14:0], byte_i[5:0]};
    seen_new         = st_i.seen + 3'd1;
    bad              = 1'b0;
    do_lead          = 1'b1;

    if (st_i.exp_len != 3'd0) begin
      if (is_cont) begin
        do_lead = 1'b0;
        if (seen_new >= st_i.exp_len) begin
          // Sequence complete: reject overlong forms and values out of range.
          bad = (acc_new > MAX_CP) ||
                ((st_i.exp_len == LEN_TWO)  && (acc_new < MIN_CP_2)) ||
                ((st_i.exp_len == LEN_THR)  && (acc_new < MIN_CP_3)) ||
                ((st_i.exp_len == LEN_FOUR) && (acc_new < MIN_CP_4));
          burst_o.has_main = 1'b1;
          burst_o.cp       = bad ? REPL_CP : acc_new;
          burst_o.ok       = !bad;
          burst_o.cnt      = st_i.exp_len;
          st_o             = '0;
        end else if (eot_i) begin
          // Text ends inside the sequence: one replacement per byte.
          burst_o.n_post = seen_new[1:0];
          st_o           = '0;
        end else begin
          st_o.acc  = acc_new;
          st_o.seen = seen_new;
        end
      end else begin
        // Broken sequence: each pending byte becomes a replacement.
        burst_o.n_pre = st_i.seen[1:0];
        st_o          = '0;
      end
    end

    if (do_lead) begin
      unique case (lead_len)
        LEN_BAD: begin
          burst_o.has_main = 1'b1;
        end
        LEN_ONE: begin
          burst_o.has_main = 1'b1;
          burst_o.cp       = {13'b0, byte_i};
          burst_o.ok       = 1'b1;
        end
        default: begin
          if (eot_i) begin
            burst_o.n_post = 2'd1;
            st_o           = '0;
          end else begin
            st_o.acc     = lead_bits;
            st_o.exp_len = lead_len;
            st_o.seen    = 3'd1;
          end
        end
      endcase
    end

    burst_o.eot = eot_i;
  end

endmodule
